// ===== rtl/ppmb_pkg.sv =====
package ppmb_pkg;

  localparam int BANK_BYTES_DEF = 4096;
  localparam int WORD_BYTES_DEF = 8;
  localparam int MAX_OUT = 32;
  localparam logic [12:0] CAP_RESET = 13'd4096;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WSTORE,
    S_RLEN,
    S_RCHK,
    S_RREQ,
    S_RDAT,
    S_RSEND
  } fsm_t;

  typedef struct packed {
    logic        op;
    logic [63:0] wdata;
    logic [3:0]  wbytes;
    logic        first_word;
    logic [7:0]  msg_len;
    logic [7:0]  read_capacity;
  } in_t;

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [63:0] rdata;
    logic [3:0]  rbytes;
    logic [7:0]  rlen;
    logic        last;
  } out_t;

endpackage

// ===== rtl/ppmb_ram.sv =====
module ppmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/ping_pong_message_buffer_top.sv =====
// Ping-pong message buffer.
// Input channel (in_valid/in_ready/in_data): write words (op 0) and read
// requests (op 1). Output channel (out_valid/out_ready/out_data): results.
// Config channel (cfg_valid/cfg_ready/cfg_data) sets bank_capacity; always ready.
// One item is handled at a time; in_ready is high only when the control FSM
// is idle and the output register is free or being drained.
// A first write word answers ok/no_space in the cycle after acceptance. The
// length byte is stored in the accepting cycle, then one payload byte per
// cycle on the single byte-wide write port, then the FSM returns to idle.
// A read fetches the length byte and checks it, then requests and captures
// each payload byte in turn from the registered RAM read port, and sends a
// result word once WORD_BYTES bytes are gathered or the message ends.
// Reset clears fill counts, read offset, bank select and write state; the
// byte store is not cleared and needs no clearing pass.
// When the receiver stalls, the result waits in the output register and the
// FSM holds before issuing its next result until it is taken; none is dropped.
module ping_pong_message_buffer_top #(
  parameter int BANK_BYTES = ppmb_pkg::BANK_BYTES_DEF,
  parameter int WORD_BYTES = ppmb_pkg::WORD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppmb_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ppmb_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [12:0]       cfg_data
);
  import ppmb_pkg::*;

  localparam int AW   = $clog2(2 * BANK_BYTES);
  localparam int FW   = $clog2(BANK_BYTES + 1);
  localparam int CW   = ((FW > 13) ? FW : 13) + 1;
  localparam int MAXB = MAX_OUT * WORD_BYTES;

  fsm_t state_r, state_nxt;
  logic          sel_r, sel_nxt;
  logic [FW-1:0] fill_r [2];
  logic [FW-1:0] fill_nxt [2];
  logic [FW-1:0] off_r, off_nxt;
  logic [7:0]    left_r, left_nxt;
  logic          drop_r, drop_nxt;
  logic [12:0]   cap_r;
  logic [63:0]   wd_r, wd_nxt;
  logic [3:0]    n_r, n_nxt, i_r, i_nxt;
  logic [7:0]    len_r, len_nxt, rcap_r, rcap_nxt;
  logic [8:0]    bidx_r, bidx_nxt, nb_r, nb_nxt;
  logic [3:0]    lane_r, lane_nxt;
  logic [63:0]   wbuf_r, wbuf_nxt;
  out_t          out_r, out_nxt;
  logic          ov_r, ov_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wbyte, rbyte;

  logic          acc, slot_free, wb;
  logic [CW-1:0] need, capsat;
  logic          reject, cur_empty, wr_go, rsend_last;
  logic [FW:0]   off_sum, rpos;
  logic [FW-1:0] wpos;

  function automatic logic [AW-1:0] mk_addr(input logic bank, input logic [FW-1:0] pos);
    mk_addr = bank ? (AW'(BANK_BYTES) + AW'(pos)) : AW'(pos);
  endfunction

  assign cfg_ready = 1'b1;
  assign slot_free = !ov_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  assign wb        = ~sel_r;
  assign capsat    = (CW'(cap_r) > CW'(BANK_BYTES)) ? CW'(BANK_BYTES) : CW'(cap_r);
  assign need      = CW'(fill_r[wb]) + CW'(in_data.msg_len) + CW'(1);
  assign reject    = need > capsat;
  assign cur_empty = off_r >= fill_r[sel_r];
  assign wr_go     = (i_r < n_r) && (left_r != 8'd0);
  assign wpos      = fill_r[wb] - FW'(left_r);
  assign off_sum   = (FW+1)'(off_r) + (FW+1)'(len_r) + (FW+1)'(1);
  assign rpos      = (FW+1)'(off_r) + (FW+1)'(1) + (FW+1)'(bidx_r);
  assign rsend_last = (bidx_r == nb_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.op == OP_WRITE) begin
            if (in_data.first_word) begin
              if (!reject) state_nxt = S_WSTORE;
            end else if (!drop_r && left_r != 8'd0) begin
              state_nxt = S_WSTORE;
            end
          end else if (!(cur_empty && fill_r[~sel_r] == '0)) begin
            state_nxt = S_RLEN;
          end
        end
      end
      S_WSTORE: if (!wr_go) state_nxt = S_IDLE;
      S_RLEN:   state_nxt = S_RCHK;
      S_RCHK: begin
        if (len_r > rcap_r || len_r == 8'd0) begin
          if (slot_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RREQ;
        end
      end
      S_RREQ: state_nxt = S_RDAT;
      S_RDAT: begin
        if (lane_r + 4'd1 == 4'(WORD_BYTES) || bidx_r + 9'd1 == nb_r) state_nxt = S_RSEND;
        else state_nxt = S_RREQ;
      end
      S_RSEND: if (slot_free) state_nxt = rsend_last ? S_IDLE : S_RREQ;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sel_nxt  = sel_r;
    fill_nxt = fill_r;
    off_nxt  = off_r;
    left_nxt = left_r;
    drop_nxt = drop_r;
    wd_nxt   = wd_r;
    n_nxt    = n_r;
    i_nxt    = i_r;
    len_nxt  = len_r;
    rcap_nxt = rcap_r;
    bidx_nxt = bidx_r;
    nb_nxt   = nb_r;
    lane_nxt = lane_r;
    wbuf_nxt = wbuf_r;
    out_nxt  = out_r;
    ov_nxt   = ov_r && !out_ready;
    we       = 1'b0;
    waddr    = mk_addr(wb, wpos);
    wbyte    = wd_r[8*i_r[2:0] +: 8];
    re       = 1'b0;
    raddr    = mk_addr(sel_r, rpos[FW-1:0]);
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          wd_nxt   = in_data.wdata;
          n_nxt    = (in_data.wbytes > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : in_data.wbytes;
          i_nxt    = 4'd0;
          rcap_nxt = in_data.read_capacity;
          if (in_data.op == OP_WRITE) begin
            if (in_data.first_word) begin
              ov_nxt = 1'b1;
              out_nxt = '{kind: KIND_WRITE, status: ST_OK, rdata: '0, rbytes: '0,
                          rlen: '0, last: 1'b1};
              if (reject) begin
                out_nxt.status = ST_NO_SPACE;
                drop_nxt = 1'b1;
                left_nxt = 8'd0;
              end else begin
                we       = 1'b1;
                waddr    = mk_addr(wb, fill_r[wb]);
                wbyte    = in_data.msg_len;
                fill_nxt[wb] = need[FW-1:0];
                left_nxt = in_data.msg_len;
                drop_nxt = 1'b0;
              end
            end
          end else begin
            re    = 1'b1;
            raddr = mk_addr(sel_r, off_r);
            if (cur_empty) begin
              fill_nxt[sel_r] = '0;
              off_nxt  = '0;
              sel_nxt  = ~sel_r;
              left_nxt = 8'd0;
              drop_nxt = 1'b0;
              raddr    = mk_addr(~sel_r, '0);
              if (fill_r[~sel_r] == '0) begin
                ov_nxt = 1'b1;
                out_nxt = '{kind: KIND_READ, status: ST_EMPTY, rdata: '0, rbytes: '0,
                            rlen: '0, last: 1'b1};
              end
            end
          end
        end
      end
      S_WSTORE: begin
        if (wr_go) begin
          we       = 1'b1;
          i_nxt    = i_r + 4'd1;
          left_nxt = left_r - 8'd1;
        end
      end
      S_RLEN: len_nxt = rbyte;
      S_RCHK: begin
        wbuf_nxt = '0;
        lane_nxt = 4'd0;
        bidx_nxt = 9'd0;
        nb_nxt   = ({1'b0, len_r} > 9'(MAXB)) ? 9'(MAXB) : {1'b0, len_r};
        if ((len_r > rcap_r || len_r == 8'd0) && slot_free) begin
          ov_nxt = 1'b1;
          out_nxt = '{kind: KIND_READ, status: ST_OK, rdata: '0, rbytes: '0,
                      rlen: '0, last: 1'b1};
          if (len_r > rcap_r) begin
            out_nxt.status = ST_TOO_LONG;
          end else if (off_sum >= (FW+1)'(fill_r[sel_r])) begin
            off_nxt = '0;
            fill_nxt[sel_r] = '0;
          end else begin
            off_nxt = off_sum[FW-1:0];
          end
        end
      end
      S_RREQ: re = 1'b1;
      S_RDAT: begin
        wbuf_nxt[8*lane_r[2:0] +: 8] = rbyte;
        lane_nxt = lane_r + 4'd1;
        bidx_nxt = bidx_r + 9'd1;
      end
      S_RSEND: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          out_nxt = '{kind: KIND_READ, status: ST_OK, rdata: wbuf_r, rbytes: lane_r,
                      rlen: len_r, last: rsend_last};
          wbuf_nxt = '0;
          lane_nxt = 4'd0;
          if (rsend_last) begin
            if (off_sum >= (FW+1)'(fill_r[sel_r])) begin
              off_nxt = '0;
              fill_nxt[sel_r] = '0;
            end else begin
              off_nxt = off_sum[FW-1:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sel_r     <= 1'b0;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      off_r     <= '0;
      left_r    <= 8'd0;
      drop_r    <= 1'b0;
      cap_r     <= CAP_RESET;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      fill_r  <= fill_nxt;
      off_r   <= off_nxt;
      left_r  <= left_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wd_r   <= wd_nxt;
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    len_r  <= len_nxt;
    rcap_r <= rcap_nxt;
    bidx_r <= bidx_nxt;
    nb_r   <= nb_nxt;
    lane_r <= lane_nxt;
    wbuf_r <= wbuf_nxt;
    out_r  <= out_nxt;
  end

  ppmb_ram #(
    .WIDTH(8),
    .DEPTH(2 * BANK_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wbyte),
    .re   (re),
    .raddr(raddr),
    .rdata(rbyte)
  );
endmodule

// ===== rtl/ppmb_checker.sv =====
module ppmb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input ppmb_pkg::out_t out_data
);
  import ppmb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_wr_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_WRITE |->
      out_data.last && (out_data.status == ST_OK || out_data.status == ST_NO_SPACE))
    else $error("bad write status");

  a_rd_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_READ &&
      (out_data.status == ST_EMPTY || out_data.status == ST_TOO_LONG) |->
      out_data.last && out_data.rlen == 8'd0 && out_data.rbytes == 4'd0)
    else $error("bad read failure result");
endmodule

bind ping_pong_message_buffer_top ppmb_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
